[hdl/hkc_pkg.sv]
// Package for the hashed key counter: table sizes, hash constants, codes.
// Used by hashed_key_counter_unit; depends on nothing else.
`default_nettype none
package hkc_pkg;

   localparam int CAPACITY      = 4096;
   localparam int ADDR_W        = $clog2(CAPACITY);
   localparam int SLOT_W        = ADDR_W + 1;
   localparam int MAX_KEY_BYTES = 8;
   localparam int KEY_W         = 8 * MAX_KEY_BYTES;
   localparam int KB_W          = 4;
   localparam int CLEAR_LEN     = CAPACITY;

   localparam logic [31:0] FNV_BASIS     = 32'd2166136261;
   // prime = 2^24 + 403
   localparam logic [8:0]  FNV_PRIME_LOW = 9'h193;

   localparam logic [SLOT_W-1:0] CAP_VAL = SLOT_W'(CAPACITY);
   localparam logic [KB_W-1:0]   MAX_KB  = KB_W'(MAX_KEY_BYTES);

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_BAD  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_PRIMARY = 2'd0,
      REG_BASE    = 2'd1,
      REG_KEYB    = 2'd2,
      REG_NONE    = 2'd3
   } reg_index_type;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_CLEAR = 8'b0000_0010,
      ST_HASH  = 8'b0000_0100,
      ST_DIV   = 8'b0000_1000,
      ST_READ  = 8'b0001_0000,
      ST_CHECK = 8'b0010_0000,
      ST_UPD   = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   function automatic logic [KEY_W-1:0] byte_mask(input logic [KB_W-1:0] n);
      logic [KEY_W-1:0] m;
      m = '0;
      for (int i = 0; i < MAX_KEY_BYTES; i++) begin
         if (KB_W'(i) < n) begin
            m[8*i +: 8] = 8'hff;
         end
      end
      return m;
   endfunction

endpackage
`default_nettype wire

[hdl/hashed_key_counter_unit.sv]
// Top level of the hashed key counter: FNV-1 hash, shared remainder unit,
// probe/chain sequencer and the slot memories. Depends on hkc_pkg.
`default_nettype none
// Counts occurrences of keys in a 4096-slot table. A request is hashed one
// byte per cycle, then reduced modulo primary_slots by a bit-serial
// remainder unit. Each probe slot costs a memory read and a compare, and
// every further probe step goes through the remainder unit again; each
// overflow chain hop costs a memory read and a compare. The slot is then
// updated and the result output. The block takes one request at a time.
// After reset and after every register write the table memories are cleared
// one slot per cycle over all 4096 slots, during which no request is taken.
module hashed_key_counter_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_key,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [11:0]      rsp_slot,
   output logic [31:0]      rsp_count,
   output logic [1:0]       rsp_status,
   output logic [12:0]      rsp_slots_used,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int AW = hkc_pkg::ADDR_W;
   localparam int SW = hkc_pkg::SLOT_W;
   localparam int KW = hkc_pkg::KEY_W;
   localparam int KBW = hkc_pkg::KB_W;

   // memories
   logic [KW-1:0] key_mem   [hkc_pkg::CAPACITY];
   logic [31:0]   count_mem [hkc_pkg::CAPACITY];
   logic [SW-1:0] link_mem  [hkc_pkg::CAPACITY];

   logic [KW-1:0] key_rd_ff;
   logic [31:0]   count_rd_ff;
   logic [SW-1:0] link_rd_ff;

   // configuration
   logic [SW-1:0]  prim_ff, base_ff;
   logic [KBW-1:0] keyb_ff;

   hkc_pkg::state_type state_ff, state_in;
   logic [SW-1:0]  clr_ff, clr_in;
   logic [SW-1:0]  used_ff, used_in;
   logic [KW-1:0]  key_ff, key_in;
   logic [KW-1:0]  mask_ff, mask_in;
   logic [KW-1:0]  kshift_ff, kshift_in;
   logic [KBW-1:0] kcnt_ff, kcnt_in;
   logic [31:0]    hash_ff, hash_in;
   logic [31:0]    h1_ff, h1_in;
   logic [31:0]    h2_ff, h2_in;
   logic [31:0]    dvd_ff, dvd_in;
   logic [SW-1:0]  rem_ff, rem_in;
   logic [4:0]     dcnt_ff, dcnt_in;
   logic           first_ff, first_in;
   logic           chain_ff, chain_in;
   logic [SW-1:0]  j_ff, j_in;
   logic [AW-1:0]  p_ff, p_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]  rsp_slot_ff, rsp_slot_in;
   logic [31:0]    rsp_count_ff, rsp_count_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic [SW-1:0]  rsp_used_ff, rsp_used_in;
   logic [AW-1:0]  res_slot_ff, res_slot_in;
   logic [31:0]    res_count_ff, res_count_in;
   logic [1:0]     res_status_ff, res_status_in;

   logic cfg_wr, clr_start, accept, bad_cfg, slot_stops;
   hkc_pkg::reg_index_type cfg_idx;
   logic [40:0]    mul_low;
   logic [31:0]    hash_step;
   logic [SW:0]    trial;
   logic [SW-1:0]  rem_step;
   logic [31:0]    h1_next;
   logic [KW-1:0]  stored;

   // memory port controls
   logic           mem_we_kc, mem_we_link;
   logic [AW-1:0]  mem_waddr;
   logic [KW-1:0]  mem_wkey;
   logic [31:0]    mem_wcount;
   logic [SW-1:0]  mem_wlink;

   assign cfg_idx = hkc_pkg::reg_index_type'(csr_paddr[3:2]);
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign clr_start = cfg_wr && (cfg_idx != hkc_pkg::REG_NONE);
   assign csr_pready = 1'b1;

   always_comb begin
      case (cfg_idx)
         hkc_pkg::REG_PRIMARY: csr_prdata = 32'(prim_ff);
         hkc_pkg::REG_BASE:    csr_prdata = 32'(base_ff);
         hkc_pkg::REG_KEYB:    csr_prdata = 32'(keyb_ff);
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prim_ff <= hkc_pkg::CAP_VAL;
         base_ff <= hkc_pkg::CAP_VAL;
         keyb_ff <= hkc_pkg::MAX_KB;
      end else if (cfg_wr) begin
         case (cfg_idx)
            hkc_pkg::REG_PRIMARY: prim_ff <= csr_pwdata[SW-1:0];
            hkc_pkg::REG_BASE:    base_ff <= csr_pwdata[SW-1:0];
            hkc_pkg::REG_KEYB:    keyb_ff <= csr_pwdata[KBW-1:0];
            default: ;
         endcase
      end
   end

   assign req_stall = (state_ff != hkc_pkg::ST_IDLE);
   assign accept = req_valid && !req_stall;
   assign bad_cfg = (prim_ff == '0) || (prim_ff > base_ff) || (base_ff > hkc_pkg::CAP_VAL)
                    || (keyb_ff == '0) || (keyb_ff > hkc_pkg::MAX_KB);

   // hash * prime, prime split as 2^24 + 403
   assign mul_low = 41'(hash_ff) * 41'(hkc_pkg::FNV_PRIME_LOW);
   assign hash_step = (mul_low[31:0] + {hash_ff[7:0], 24'd0}) ^ 32'(kshift_ff[7:0]);

   // one remainder bit per cycle
   assign trial = {rem_ff, dvd_ff[31]};
   assign rem_step = (trial >= {1'b0, prim_ff}) ? SW'(trial - {1'b0, prim_ff})
                                                : trial[SW-1:0];

   assign h1_next = h1_ff + h2_ff;
   assign stored = key_rd_ff & mask_ff;
   assign slot_stops = (stored == '0) || (stored == key_ff);

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      used_in = used_ff;
      key_in = key_ff;
      mask_in = mask_ff;
      kshift_in = kshift_ff;
      kcnt_in = kcnt_ff;
      hash_in = hash_ff;
      h1_in = h1_ff;
      h2_in = h2_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      dcnt_in = dcnt_ff;
      first_in = first_ff;
      chain_in = chain_ff;
      j_in = j_ff;
      p_in = p_ff;
      res_slot_in = res_slot_ff;
      res_count_in = res_count_ff;
      res_status_in = res_status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_slot_in = rsp_slot_ff;
      rsp_count_in = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      rsp_used_in = rsp_used_ff;
      mem_we_kc = 1'b0;
      mem_we_link = 1'b0;
      mem_waddr = p_ff;
      mem_wkey = key_ff;
      mem_wcount = count_rd_ff + 32'd1;
      mem_wlink = used_ff + SW'(1);

      case (state_ff)
         hkc_pkg::ST_IDLE: begin
            if (accept) begin
               res_slot_in = '0;
               res_count_in = '0;
               if (bad_cfg) begin
                  res_status_in = hkc_pkg::STATUS_BAD;
                  state_in = hkc_pkg::ST_OUT;
               end else begin
                  mask_in = hkc_pkg::byte_mask(keyb_ff);
                  key_in = req_key & hkc_pkg::byte_mask(keyb_ff);
                  kshift_in = req_key;
                  kcnt_in = '0;
                  hash_in = hkc_pkg::FNV_BASIS;
                  state_in = hkc_pkg::ST_HASH;
               end
            end
         end
         hkc_pkg::ST_CLEAR: begin
            mem_we_kc = 1'b1;
            mem_we_link = 1'b1;
            mem_waddr = clr_ff[AW-1:0];
            mem_wkey = '0;
            mem_wcount = '0;
            mem_wlink = '0;
            clr_in = clr_ff + SW'(1);
            if (clr_ff == SW'(hkc_pkg::CLEAR_LEN - 1)) begin
               state_in = hkc_pkg::ST_IDLE;
            end
         end
         hkc_pkg::ST_HASH: begin
            hash_in = hash_step;
            kshift_in = kshift_ff >> 8;
            kcnt_in = kcnt_ff + KBW'(1);
            if (kcnt_ff + KBW'(1) == keyb_ff) begin
               dvd_in = hash_step;
               rem_in = '0;
               dcnt_in = '0;
               first_in = 1'b1;
               chain_in = 1'b0;
               j_in = '0;
               state_in = hkc_pkg::ST_DIV;
            end
         end
         hkc_pkg::ST_DIV: begin
            rem_in = rem_step;
            dvd_in = dvd_ff << 1;
            dcnt_in = dcnt_ff + 5'd1;
            if (dcnt_ff == 5'd31) begin
               p_in = rem_step[AW-1:0];
               if (first_ff) begin
                  h1_in = 32'(rem_step);
                  h2_in = 32'(rem_step) | 32'd1;
                  first_in = 1'b0;
               end
               state_in = hkc_pkg::ST_READ;
            end
         end
         hkc_pkg::ST_READ: begin
            state_in = hkc_pkg::ST_CHECK;
         end
         hkc_pkg::ST_CHECK: begin
            if (slot_stops) begin
               state_in = hkc_pkg::ST_UPD;
            end else if (!chain_ff) begin
               // next probe position
               j_in = j_ff + SW'(1);
               h1_in = h1_next;
               dvd_in = h1_next;
               rem_in = '0;
               dcnt_in = '0;
               if (j_ff + SW'(1) == prim_ff) begin
                  chain_in = 1'b1;
               end
               state_in = hkc_pkg::ST_DIV;
            end else if (link_rd_ff != '0) begin
               p_in = AW'(link_rd_ff - SW'(1));
               state_in = hkc_pkg::ST_READ;
            end else if (used_ff >= hkc_pkg::CAP_VAL) begin
               res_status_in = hkc_pkg::STATUS_FULL;
               state_in = hkc_pkg::ST_OUT;
            end else begin
               // append a fresh overflow slot
               mem_we_link = 1'b1;
               used_in = used_ff + SW'(1);
               p_in = used_ff[AW-1:0];
               state_in = hkc_pkg::ST_READ;
            end
         end
         hkc_pkg::ST_UPD: begin
            mem_we_kc = 1'b1;
            res_slot_in = p_ff;
            res_count_in = count_rd_ff + 32'd1;
            res_status_in = hkc_pkg::STATUS_OK;
            state_in = hkc_pkg::ST_OUT;
         end
         hkc_pkg::ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_slot_in = res_slot_ff;
               rsp_count_in = res_count_ff;
               rsp_status_in = res_status_ff;
               rsp_used_in = used_ff;
               state_in = hkc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hkc_pkg::ST_IDLE;
         end
      endcase

      if (clr_start) begin
         // any register write restarts the table clear
         state_in = hkc_pkg::ST_CLEAR;
         clr_in = '0;
         used_in = (cfg_idx == hkc_pkg::REG_BASE) ? csr_pwdata[SW-1:0] : base_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hkc_pkg::ST_CLEAR;
         clr_ff <= '0;
         used_ff <= hkc_pkg::CAP_VAL;
         rsp_valid_ff <= 1'b0;
         first_ff <= 1'b0;
         chain_ff <= 1'b0;
         j_ff <= '0;
         kcnt_ff <= '0;
         dcnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         used_ff <= used_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff <= first_in;
         chain_ff <= chain_in;
         j_ff <= j_in;
         kcnt_ff <= kcnt_in;
         dcnt_ff <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      mask_ff <= mask_in;
      kshift_ff <= kshift_in;
      hash_ff <= hash_in;
      h1_ff <= h1_in;
      h2_ff <= h2_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      p_ff <= p_in;
      res_slot_ff <= res_slot_in;
      res_count_ff <= res_count_in;
      res_status_ff <= res_status_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_count_ff <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_used_ff <= rsp_used_in;
   end

   // slot memories: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we_kc) begin
         key_mem[mem_waddr] <= mem_wkey;
         count_mem[mem_waddr] <= mem_wcount;
      end
      if (mem_we_link) begin
         link_mem[mem_waddr] <= mem_wlink;
      end
      key_rd_ff <= key_mem[p_ff];
      count_rd_ff <= count_mem[p_ff];
      link_rd_ff <= link_mem[p_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_slot = rsp_slot_ff;
   assign rsp_count = rsp_count_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slots_used = rsp_used_ff;

   // an out-of-range base_slots setting loads the pointer past capacity as is
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      (used_ff <= hkc_pkg::CAP_VAL) || (used_ff == base_ff))
      else $error("allocation pointer past capacity");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == hkc_pkg::STATUS_FULL |-> rsp_slots_used == hkc_pkg::CAP_VAL)
      else $error("table full reported below capacity");

   a_probe_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == hkc_pkg::ST_CHECK && !chain_ff |-> j_ff < prim_ff)
      else $error("probe count ran past primary slots");

endmodule
`default_nettype wire
